// ===== design/nearest_landmark_association_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for nearest_landmark_association_top
// Shorthand for clocked concurrent checks, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef NEAREST_LANDMARK_ASSOCIATION_TOP_ASSERT_SVH
`define NEAREST_LANDMARK_ASSOCIATION_TOP_ASSERT_SVH

// same-cycle implication
`define NLA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NLA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/nla_pkg.sv =====
// ---------------------------------------------------------------------------
// nla_pkg
// Shared types and constants of the nearest landmark association block.
// ---------------------------------------------------------------------------
package nla_pkg;

	localparam int IDX_W  = 6;
	localparam int DIST_W = 50;
	localparam int SUM_W  = 64;
	localparam int OUT_W  = ((IDX_W + DIST_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef struct packed {
		logic vld;
		logic last;
	} nla_tag_t;

endpackage

// ===== design/nla_ram.sv =====
// ---------------------------------------------------------------------------
// nla_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module nla_ram #(
	parameter int WIDTH  = 48,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/nla_dist.sv =====
// ---------------------------------------------------------------------------
// nla_dist
// Shared distance unit: absolute gaps, squares and saturating sum, one
// landmark entry per cycle.
// ---------------------------------------------------------------------------
module nla_dist #(
	parameter int COORD_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nla_pkg::nla_tag_t       rd_tag,
	input  logic [COORD_BITS-1:0]   obs_x,
	input  logic [COORD_BITS-1:0]   obs_y,
	input  logic [2*COORD_BITS-1:0] lm_data,
	output nla_pkg::nla_tag_t       out_tag,
	output logic [nla_pkg::SUM_W-1:0] sq_dist
);

	import nla_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int EXTW = SUM_W + 1 - 2 * CW;

	nla_tag_t          tag_s0, tag_s1, tag_s2, tag_s3;
	logic [CW-1:0]     lm_x, lm_y;
	logic [CW-1:0]     dx_s1, dy_s1;
	logic [2*CW-1:0]   sq_x_s2, sq_y_s2;
	logic [SUM_W:0]    sum;
	logic [SUM_W-1:0]  d_s3;

	assign lm_x = lm_data[CW-1:0];
	assign lm_y = lm_data[2*CW-1:CW];
	assign sum  = {{EXTW{1'b0}}, sq_x_s2} + {{EXTW{1'b0}}, sq_y_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s0 <= '0;
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s0 <= rd_tag;
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= (lm_x > obs_x) ? (lm_x - obs_x) : (obs_x - lm_x);
		dy_s1   <= (lm_y > obs_y) ? (lm_y - obs_y) : (obs_y - lm_y);
		sq_x_s2 <= dx_s1 * dx_s1;
		sq_y_s2 <= dy_s1 * dy_s1;
		d_s3    <= sum[SUM_W] ? '1 : sum[SUM_W-1:0];
	end

	assign out_tag = tag_s3;
	assign sq_dist = d_s3;

endmodule

// ===== design/nearest_landmark_association_top.sv =====
// Query with N stored landmarks: the entries are scanned and the nearest result is
// registered (at once for an empty table); the next request is accepted when that
// result enters the output register, later while an earlier result waits on m_axis_tready.
// One table entry per cycle feeds the shared distance unit, followed by the read,
// distance, compare and output stages. Clear and load requests give no result.
// Reset (arst_n low) empties the table and drops any pending result.
// ---------------------------------------------------------------------------
// nearest_landmark_association_top
// Landmark table with nearest-neighbor search by squared distance.
// ---------------------------------------------------------------------------
module nearest_landmark_association_top #(
	parameter int MAX_LANDMARKS = 64,
	parameter int COORD_BITS    = 24,
	localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_W-1:0]          s_axis_tdata,  // x_coord, y_coord
	input  logic [1:0]               s_axis_tuser,  // kind
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [nla_pkg::OUT_W-1:0] m_axis_tdata, // nearest_index, distance_sq
	output logic [0:0]               m_axis_tuser   // found
);

	import nla_pkg::*;

	`include "nearest_landmark_association_top_assert.svh"

	localparam int CW    = COORD_BITS;
	localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
	localparam int AW    = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_addr_q;
	logic [CNT_W-1:0]   cmp_idx_q;
	logic               issue_q;
	logic               have_q;
	logic [AW-1:0]      best_idx_q;
	logic [SUM_W-1:0]   best_d_q;
	logic [CW-1:0]      obs_x_q, obs_y_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               m_tvalid_q;
	logic               m_found_q;

	logic               accept;
	logic [CW-1:0]      in_ox, in_oy;
	logic               ram_we;
	logic [2*CW-1:0]    ram_rdata;
	logic               last_rd;
	nla_tag_t           rd_tag, out_tag;
	logic [SUM_W-1:0]   cand_dist;
	logic               take;
	logic [IDX_W+AW-1:0] idx_ext;
	logic [DIST_W-1:0]  dist_out;
	logic               emit;
	logic [OUT_W-1:0]   result_word;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_ox = {~s_axis_tdata[CW-1], s_axis_tdata[CW-2:0]};
	assign in_oy = {~s_axis_tdata[2*CW-1], s_axis_tdata[2*CW-2:CW]};
	assign ram_we = accept && (s_axis_tuser == KIND_LOAD) &&
		(count_q < CNT_W'(MAX_LANDMARKS));

	assign last_rd     = (rd_addr_q == count_q - CNT_W'(1));
	assign rd_tag.vld  = (state_q == ST_SCAN) && issue_q;
	assign rd_tag.last = last_rd;

	assign take     = (cmp_idx_q == '0) || (cand_dist < best_d_q);
	assign idx_ext  = {{IDX_W{1'b0}}, best_idx_q};
	assign dist_out = (|best_d_q[SUM_W-1:DIST_W]) ? '1 : best_d_q[DIST_W-1:0];
	assign emit     = (state_q == ST_DONE) && (!m_tvalid_q || m_axis_tready);

	always_comb begin
		result_word = '0;
		result_word[IDX_W-1:0]            = idx_ext[IDX_W-1:0];
		result_word[IDX_W+DIST_W-1:IDX_W] = dist_out;
	end

	nla_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_LANDMARKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({in_oy, in_ox}),
		.re    (rd_tag.vld),
		.raddr (rd_addr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	nla_dist #(
		.COORD_BITS (CW)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_tag  (rd_tag),
		.obs_x   (obs_x_q),
		.obs_y   (obs_y_q),
		.lm_data (ram_rdata),
		.out_tag (out_tag),
		.sq_dist (cand_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_addr_q  <= '0;
			cmp_idx_q  <= '0;
			issue_q    <= 1'b0;
			have_q     <= 1'b0;
			best_idx_q <= '0;
			best_d_q   <= '0;
			obs_x_q    <= '0;
			obs_y_q    <= '0;
			m_tdata_q  <= '0;
			m_tvalid_q <= 1'b0;
			m_found_q  <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
				m_found_q  <= have_q;
				m_tdata_q  <= result_word;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_axis_tuser)
							KIND_CLEAR: count_q <= '0;
							KIND_LOAD: begin
								if (ram_we) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							KIND_QUERY: begin
								obs_x_q    <= in_ox;
								obs_y_q    <= in_oy;
								rd_addr_q  <= '0;
								cmp_idx_q  <= '0;
								best_idx_q <= '0;
								best_d_q   <= '0;
								have_q     <= (count_q != '0);
								issue_q    <= (count_q != '0);
								state_q    <= (count_q != '0) ? ST_SCAN : ST_DONE;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_tag.vld) begin
						rd_addr_q <= rd_addr_q + CNT_W'(1);
						if (last_rd) begin
							issue_q <= 1'b0;
						end
					end
					if (out_tag.vld) begin
						cmp_idx_q <= cmp_idx_q + CNT_W'(1);
						if (take) begin
							best_d_q   <= cand_dist;
							best_idx_q <= cmp_idx_q[AW-1:0];
						end
						if (out_tag.last) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid   = m_tvalid_q;
	assign m_axis_tdata    = m_tdata_q;
	assign m_axis_tuser[0] = m_found_q;

	`NLA_ASSERT_IMP(a_count_max, 1'b1, count_q <= CNT_W'(MAX_LANDMARKS), "table count overflow")
	`NLA_ASSERT_IMP(a_tag_in_scan, out_tag.vld, state_q == ST_SCAN, "distance result outside scan")
	`NLA_ASSERT_NXT(a_done_emits, emit, m_axis_tvalid && state_q == ST_IDLE, "query not presented")
	`NLA_ASSERT_IMP(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "empty not zero")
	`NLA_ASSERT_NXT(a_query_start, accept && s_axis_tuser == KIND_QUERY, state_q != ST_IDLE, "query stuck")

endmodule

// ===== tb/nearest_landmark_association_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nearest_landmark_association_top_test
// Self-checking bench: drives clear, load, query and unused-kind requests with
// random stalls on both streams (none in a calm phase) and compares each answer
// with a local nearest-match predictor of the landmark table or a directed value.
// ---------------------------------------------------------------------------
module nearest_landmark_association_top_test;
	import nla_pkg::*;

	localparam int COORD_W         = 24;
	localparam int IN_W            = ((2 * COORD_W + 7) / 8) * 8;
	localparam int TABLE_DEPTH     = 64;
	localparam int TARGET_REQUESTS = 1200;
	localparam int DRAIN_CYCLES    = 80;
	localparam int ROW_COUNT       = 22;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic [DIST_W-1:0] EDGE_SQ   = 50'd281474943156225;
	localparam logic [DIST_W-1:0] CORNER_SQ = 50'd562949886312450;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic              found;
		logic [DIST_W-1:0] range_sq;
	} match_t;

	typedef struct {
		logic [1:0]                 kind;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		bit                         typed;
		match_t                     want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;     // x_coord, y_coord
	logic [1:0] s_axis_tuser = KIND_CLEAR;  // kind
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;         // nearest_index, distance_sq
	logic [0:0] m_axis_tuser;               // found

	logic signed [COORD_W-1:0] lm_x [TABLE_DEPTH];
	logic signed [COORD_W-1:0] lm_y [TABLE_DEPTH];
	int lm_count = 0;

	match_t pending_matches [$];
	bit calm = 1'b0;
	int fail_count = 0;
	int useful_count = 0;
	int dropped_loads = 0;
	int ignored_count = 0;
	int query_count = 0;
	int empty_queries = 0;
	int checked_count = 0;
	stim_row_t directed_rows [ROW_COUNT];

	nearest_landmark_association_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("nearest_landmark_association_top_test NOT OK");
		$finish;
	end

	function automatic bit apply_request(input logic [1:0] kind,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			output match_t res);
		longint dx;
		longint dy;
		longint d;
		longint best;
		res = '0;
		best = 0;
		case (kind)
			KIND_CLEAR: begin
				lm_count = 0;
				return 1'b0;
			end
			KIND_LOAD: begin
				if (lm_count < TABLE_DEPTH) begin
					lm_x[lm_count] = x;
					lm_y[lm_count] = y;
					lm_count++;
				end
				return 1'b0;
			end
			KIND_QUERY: begin
				for (int i = 0; i < lm_count; i++) begin
					dx = longint'(x) - longint'(lm_x[i]);
					dy = longint'(y) - longint'(lm_y[i]);
					d = dx * dx + dy * dy;
					if (!res.found || d < best) begin
						res.found = 1'b1;
						res.index = IDX_W'(i);
						best = d;
					end
				end
				res.range_sq = best[DIST_W-1:0];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(2))
			0: return COORD_W'($urandom);
			1: return COORD_W'(int'($urandom_range(2047)) - 1024);
			default: begin
				case ($urandom_range(3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	task automatic send_request(input logic [1:0] kind,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input bit typed, input match_t want);
		match_t pred;
		bit has_res;
		while (!calm && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (kind == KIND_UNUSED)
			ignored_count++;
		else if (kind == KIND_LOAD && lm_count >= TABLE_DEPTH)
			dropped_loads++;
		else
			useful_count++;
		if (kind == KIND_QUERY) begin
			query_count++;
			if (lm_count == 0)
				empty_queries++;
		end
		has_res = apply_request(kind, x, y, pred);
		if (has_res)
			pending_matches.insert(pending_matches.size(), typed ? want : pred);
	endtask

	always @(posedge clk) begin : result_check
		match_t head;
		m_axis_tready <= calm || ($urandom_range(99) >= 8);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_matches.size() == 0) begin
				$error("result with no request pending: index %0d found %0d dist %0d",
					m_axis_tdata[IDX_W-1:0], m_axis_tuser[0], m_axis_tdata[IDX_W +: DIST_W]);
				fail_count++;
			end else begin
				head = pending_matches.pop_front();
				checked_count++;
				if (m_axis_tdata[IDX_W-1:0] !== head.index) begin
					$error("nearest_index: expected %0d, got %0d",
						head.index, m_axis_tdata[IDX_W-1:0]);
					fail_count++;
				end
				if (m_axis_tuser[0] !== head.found) begin
					$error("found: expected %0d, got %0d", head.found, m_axis_tuser[0]);
					fail_count++;
				end
				if (m_axis_tdata[IDX_W +: DIST_W] !== head.range_sq) begin
					$error("distance_sq: expected %0d, got %0d",
						head.range_sq, m_axis_tdata[IDX_W +: DIST_W]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		int n;
		int pick;

		directed_rows = '{
			'{KIND_QUERY,  24'sd0,   24'sd0,   1'b1, '{6'd0, 1'b0, 50'd0}},
			'{KIND_UNUSED, COORD_MAX, -24'sd1, 1'b0, '0},
			'{KIND_LOAD,   COORD_MIN, COORD_MIN, 1'b0, '0},
			'{KIND_LOAD,   COORD_MAX, COORD_MAX, 1'b0, '0},
			'{KIND_QUERY,  COORD_MAX, COORD_MIN, 1'b1, '{6'd0, 1'b1, EDGE_SQ}},
			'{KIND_QUERY,  COORD_MIN, COORD_MAX, 1'b1, '{6'd0, 1'b1, EDGE_SQ}},
			'{KIND_QUERY,  COORD_MAX, COORD_MAX, 1'b1, '{6'd1, 1'b1, 50'd0}},
			'{KIND_QUERY,  COORD_MIN, COORD_MIN, 1'b1, '{6'd0, 1'b1, 50'd0}},
			'{KIND_CLEAR,  24'sd0,   24'sd0,   1'b0, '0},
			'{KIND_QUERY,  24'sd5,   24'sd5,   1'b1, '{6'd0, 1'b0, 50'd0}},
			'{KIND_LOAD,   COORD_MIN, COORD_MIN, 1'b0, '0},
			'{KIND_QUERY,  COORD_MAX, COORD_MAX, 1'b1, '{6'd0, 1'b1, CORNER_SQ}},
			'{KIND_CLEAR,  COORD_MAX, COORD_MIN, 1'b0, '0},
			'{KIND_LOAD,   24'sd0,   24'sd0,   1'b0, '0},
			'{KIND_LOAD,   24'sd0,   24'sd0,   1'b0, '0},
			'{KIND_LOAD,   24'sd256, 24'sd0,   1'b0, '0},
			'{KIND_QUERY,  24'sd1,   -24'sd1,  1'b0, '0},
			'{KIND_QUERY,  24'sd200, 24'sd0,   1'b0, '0},
			'{KIND_UNUSED, COORD_MIN, COORD_MAX, 1'b0, '0},
			'{KIND_QUERY,  -24'sd1,  -24'sd1,  1'b0, '0},
			'{KIND_LOAD,   COORD_MIN, COORD_MAX, 1'b0, '0},
			'{KIND_QUERY,  -24'sd8388000, 24'sd8388000, 1'b0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_request(directed_rows[r].kind, directed_rows[r].x, directed_rows[r].y,
				directed_rows[r].typed, directed_rows[r].want);

		while (useful_count < TARGET_REQUESTS) begin
			calm = (useful_count >= 500 && useful_count < 750);
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(4) != 0)
					send_request(KIND_CLEAR, rand_coord(), rand_coord(), 1'b0, '0);
				n = ($urandom_range(9) == 0) ? TABLE_DEPTH + $urandom_range(1, 4)
					: $urandom_range(1, 12);
				for (int k = 0; k < n; k++) begin
					if (k > 0 && lm_count > 0 && $urandom_range(6) == 0) begin
						x = lm_x[lm_count-1];
						y = lm_y[lm_count-1];
					end else begin
						x = rand_coord();
						y = rand_coord();
					end
					send_request(KIND_LOAD, x, y, 1'b0, '0);
				end
				n = $urandom_range(2, 8);
				for (int k = 0; k < n; k++) begin
					if (lm_count > 0 && $urandom_range(2) != 0) begin
						pick = $urandom_range(lm_count - 1);
						x = lm_x[pick] + COORD_W'(int'($urandom_range(64)) - 32);
						y = lm_y[pick] + COORD_W'(int'($urandom_range(64)) - 32);
					end else begin
						x = rand_coord();
						y = rand_coord();
					end
					if ($urandom_range(19) == 0)
						send_request(KIND_UNUSED, rand_coord(), rand_coord(), 1'b0, '0);
					send_request(KIND_QUERY, x, y, 1'b0, '0);
				end
			end else begin
				repeat ($urandom_range(1, 4))
					send_request(2'($urandom_range(3)), rand_coord(), rand_coord(), 1'b0, '0);
			end
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d queries (%0d on an empty table), %0d loads dropped at full",
			useful_count + dropped_loads + ignored_count, query_count, empty_queries, dropped_loads);
		$display("Ignored kind requests: %0d, results checked: %0d, mismatches: %0d",
			ignored_count, checked_count, fail_count);
		if (fail_count == 0)
			$display("nearest_landmark_association_top_test OK");
		else
			$display("nearest_landmark_association_top_test NOT OK");
		$finish;
	end

endmodule

// ===== nearest_landmark_association_top.f =====
+incdir+design
design/nla_pkg.sv
design/nla_ram.sv
design/nla_dist.sv
design/nearest_landmark_association_top.sv
tb/nearest_landmark_association_top_test.sv
